FILE: src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and codes of the bitplane row to chunky decoder
// Holds the plane phase codes, register indexes and the job record that
// travels from the byte front end to the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  typedef enum logic [1:0] {
    PH_PLANE0 = 2'd0,
    PH_PLANE1 = 2'd1,
    PH_PLANE2 = 2'd2,
    PH_PLANE3 = 2'd3
  } plane_phase_t;

  localparam logic [1:0] CFG_ROW_BYTES    = 2'd0;
  localparam logic [1:0] CFG_HEADER_BYTES = 2'd1;
  localparam logic [1:0] CFG_IMAGE_ROWS   = 2'd2;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] plane0;
    logic [7:0] plane1;
    logic [7:0] plane2;
    logic [7:0] plane3;
    logic [3:0] group;
    logic [7:0] row;
    logic       image_end;
  } pixel_job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: src/bitplane_row_to_chunky_decoder_unit.sv
// ----------------------------------------------------------------------------
// bitplane_row_to_chunky_decoder_unit: four-bitplane planar to chunky decoder
// Skips each image header, gathers plane 0..2 row bytes and turns every
// plane-3 byte into eight 4-bit pixel indices with x, y and last flags.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   config  | cfg_write           | cfg_index, cfg_data
//   input   | in_valid / in_stall | data_byte
//   output  | out_valid/out_stall | pixel_index, pixel_x, pixel_y,
//           |                     | group_last, image_last
//
// One byte is taken per cycle while in_stall is low; a plane-3 byte yields
// eight output beats at one per cycle from the back end while out_stall is
// low, so the sustained rate over a row is set by the pixel walk (four bytes per group).
// The front stalls input only when the two-entry job queue is full.
// Synchronous reset restores register defaults and starts in the header.
// ----------------------------------------------------------------------------
`default_nettype none

module bitplane_row_to_chunky_decoder_unit #(
  parameter int unsigned MAX_ROW_BYTES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      pixel_index,
  output logic [6:0]      pixel_x,
  output logic [7:0]      pixel_y,
  output logic            group_last,
  output logic            image_last
);
  import bpc_pkg::*;

  queue_ctrl_t   q_ctrl;
  queue_status_t q_status;
  pixel_job_t    new_job, head_job;
  logic          push, pop;

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  bpc_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .q_status  (q_status),
    .push      (push),
    .job       (new_job)
  );

  bpc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (q_ctrl),
    .wr_job (new_job),
    .status (q_status),
    .head   (head_job)
  );

  bpc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_job),
    .head_valid  (q_status.not_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .group_last  (group_last),
    .image_last  (image_last)
  );

endmodule

`default_nettype wire

FILE: src/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: byte front end
// Skips header bytes, tracks plane, group and row, keeps plane 0..2 bytes in
// row stores and hands one job per plane-3 byte to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_front #(
  parameter int unsigned MAX_ROW_BYTES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          data_byte,
  input  wire bpc_pkg::queue_status_t q_status,
  output logic                     push,
  output bpc_pkg::pixel_job_t      job
);
  import bpc_pkg::*;

  localparam int unsigned GW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam logic [7:0] MaxRb = 8'(MAX_ROW_BYTES);

  logic [4:0] row_bytes;
  logic [5:0] header_bytes;
  logic [7:0] image_rows;

  logic         in_header, in_header_next;
  logic [5:0]   header_count, header_count_next;
  plane_phase_t plane_phase, plane_phase_next;
  logic [GW-1:0] group_index, group_index_next;
  logic [7:0]   row_index, row_index_next;

  logic [7:0] plane0_store [MAX_ROW_BYTES];
  logic [7:0] plane1_store [MAX_ROW_BYTES];
  logic [7:0] plane2_store [MAX_ROW_BYTES];
  logic [7:0] rd0, rd1, rd2;

  logic       accept, is_header, is_data;
  logic [7:0] rb8, g_inc8, g_ext8;
  logic [8:0] rows9, row_inc9;
  logic [5:0] hc_inc;
  logic       last_group, last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes    <= 5'd3;
      header_bytes <= 6'd8;
      image_rows   <= 8'd24;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROW_BYTES:    row_bytes    <= cfg_data[4:0];
        CFG_HEADER_BYTES: header_bytes <= cfg_data[5:0];
        CFG_IMAGE_ROWS:   image_rows   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (row_bytes == 5'd0) begin
      rb8 = 8'd1;
    end else if ({3'd0, row_bytes} > MaxRb) begin
      rb8 = MaxRb;
    end else begin
      rb8 = {3'd0, row_bytes};
    end
    rows9 = (image_rows == 8'd0) ? 9'd1 : {1'b0, image_rows};
  end

  assign g_ext8     = 8'(group_index);
  assign g_inc8     = g_ext8 + 8'd1;
  assign row_inc9   = {1'b0, row_index} + 9'd1;
  assign hc_inc     = header_count + 6'd1;
  assign is_header  = in_header && (header_count < header_bytes);
  assign is_data    = accept && !is_header;
  assign last_group = (g_inc8 >= rb8);
  assign last_row   = (row_inc9 >= rows9);

  always_comb begin
    in_header_next    = in_header;
    header_count_next = header_count;
    plane_phase_next  = plane_phase;
    group_index_next  = group_index;
    row_index_next    = row_index;
    if (accept) begin
      if (is_header) begin
        header_count_next = hc_inc;
        if (hc_inc >= header_bytes) begin
          in_header_next = 1'b0;
        end
      end else begin
        in_header_next = 1'b0;
        if (last_group) begin
          group_index_next = '0;
          if (plane_phase == PH_PLANE3) begin
            plane_phase_next = PH_PLANE0;
            if (last_row) begin
              row_index_next    = 8'd0;
              in_header_next    = 1'b1;
              header_count_next = 6'd0;
            end else begin
              row_index_next = row_inc9[7:0];
            end
          end else begin
            plane_phase_next = plane_phase_t'(plane_phase + 2'd1);
          end
        end else begin
          group_index_next = g_inc8[GW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header    <= 1'b1;
      header_count <= 6'd0;
      plane_phase  <= PH_PLANE0;
      group_index  <= '0;
      row_index    <= 8'd0;
    end else begin
      in_header    <= in_header_next;
      header_count <= header_count_next;
      plane_phase  <= plane_phase_next;
      group_index  <= group_index_next;
      row_index    <= row_index_next;
    end
  end

  // write at the current group, read ahead at the next one; bypass on a match
  always_ff @(posedge clk) begin
    if (is_data && plane_phase == PH_PLANE0) begin
      plane0_store[group_index] <= data_byte;
    end
    if (is_data && plane_phase == PH_PLANE1) begin
      plane1_store[group_index] <= data_byte;
    end
    if (is_data && plane_phase == PH_PLANE2) begin
      plane2_store[group_index] <= data_byte;
    end
    if (is_data && plane_phase == PH_PLANE0 && group_index == group_index_next) begin
      rd0 <= data_byte;
    end else begin
      rd0 <= plane0_store[group_index_next];
    end
    if (is_data && plane_phase == PH_PLANE1 && group_index == group_index_next) begin
      rd1 <= data_byte;
    end else begin
      rd1 <= plane1_store[group_index_next];
    end
    if (is_data && plane_phase == PH_PLANE2 && group_index == group_index_next) begin
      rd2 <= data_byte;
    end else begin
      rd2 <= plane2_store[group_index_next];
    end
  end

  assign push = is_data && (plane_phase == PH_PLANE3);

  always_comb begin
    job.plane0    = rd0;
    job.plane1    = rd1;
    job.plane2    = rd2;
    job.plane3    = data_byte;
    job.group     = g_ext8[3:0];
    job.row       = row_index;
    job.image_end = last_group && last_row;
  end

endmodule

`default_nettype wire

FILE: src/bpc_queue.sv
// ----------------------------------------------------------------------------
// bpc_queue: job queue
// Short first-in first-out buffer that decouples the byte front end from
// the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bpc_pkg::queue_ctrl_t  ctrl,
  input  wire bpc_pkg::pixel_job_t   wr_job,
  output bpc_pkg::queue_status_t     status,
  output bpc_pkg::pixel_job_t        head
);
  import bpc_pkg::*;

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [PW:0] DepthCount = (PW + 1)'(QueueDepth);
  localparam logic [PW-1:0] LastSlot = PW'(QueueDepth - 1);

  pixel_job_t  slots [QueueDepth];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign status.full      = (count == DepthCount);
  assign status.not_empty = (count != '0);
  assign head             = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + PW'(1);
      end
      if (ctrl.pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + PW'(1);
      end
      case ({ctrl.push, ctrl.pop})
        2'b10:   count <= count + (PW + 1)'(1);
        2'b01:   count <= count - (PW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back: pixel back end
// Walks the eight pixels of the job at the queue head, MSB first, into a
// registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire bpc_pkg::pixel_job_t    head,
  input  wire logic                   head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [3:0]                  pixel_index,
  output logic [6:0]                  pixel_x,
  output logic [7:0]                  pixel_y,
  output logic                        group_last,
  output logic                        image_last
);
  import bpc_pkg::*;

  logic [2:0] pix;
  logic [2:0] sh;
  logic       advance, emit, final_pix;

  assign advance   = !out_valid || !out_stall;
  assign emit      = advance && head_valid;
  assign final_pix = (pix == 3'd7);
  assign sh        = 3'd7 - pix;
  assign pop       = emit && final_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pix       <= 3'd0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        pix <= pix + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_index <= {head.plane3[sh], head.plane2[sh], head.plane1[sh], head.plane0[sh]};
      pixel_x     <= {head.group, pix};
      pixel_y     <= head.row;
      group_last  <= final_pix;
      image_last  <= final_pix && head.image_end;
    end
  end

endmodule

`default_nettype wire

FILE: verif/bitplane_row_to_chunky_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitplane_row_to_chunky_decoder_unit_tb: self-checking bench of the decoder
// Streams image files (header, then four bitplane byte runs per row) into the
// block with random input gaps and output stalls. A tracker class follows the
// header skip, the row stores and the row and column counters, and it lists
// the eight pixel beats due for every plane-3 byte. Each beat that leaves the
// block is compared against the oldest listed one. Registers change only
// while the block is idle. This covers zero and clamped values, a header cut
// short, a row narrowed mid-image and the row count lowered mid-image.
// ----------------------------------------------------------------------------

import bpc_pkg::*;

localparam int unsigned RowBytesMax = 16;

typedef struct packed {
  logic [3:0] color;
  logic [6:0] x;
  logic [7:0] y;
  logic       group_end;
  logic       image_end;
} pixel_beat_t;

class plane_merge_tracker;
  logic [4:0]   width_reg;
  logic [5:0]   skip_reg;
  logic [7:0]   rows_reg;
  logic [7:0]   plane0_row [RowBytesMax];
  logic [7:0]   plane1_row [RowBytesMax];
  logic [7:0]   plane2_row [RowBytesMax];
  int unsigned  header_seen;
  int unsigned  group;
  int unsigned  row;
  plane_phase_t phase;
  bit           skipping;
  pixel_beat_t  pixels_due [$];
  int unsigned  stream_bytes;
  int unsigned  data_bytes;
  int unsigned  images;
  int unsigned  pixels_seen;
  int unsigned  failures;
  int unsigned  reg_writes;

  function new();
    width_reg = 5'd3;
    skip_reg = 6'd8;
    rows_reg = 8'd24;
    foreach (plane0_row[k]) begin
      plane0_row[k] = 8'h00;
      plane1_row[k] = 8'h00;
      plane2_row[k] = 8'h00;
    end
    header_seen = 0;
    group = 0;
    row = 0;
    phase = PH_PLANE0;
    skipping = 1'b1;
  endfunction

  function int unsigned row_width();
    if (width_reg == 0) return 1;
    if (width_reg > RowBytesMax) return RowBytesMax;
    return width_reg;
  endfunction

  function int unsigned image_depth();
    return (rows_reg == 0) ? 1 : rows_reg;
  endfunction

  function int unsigned pending();
    return pixels_due.size();
  endfunction

  function bit at_image_start();
    return skipping && header_seen == 0 && phase == PH_PLANE0 && group == 0 && row == 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] value);
    reg_writes++;
    case (idx)
      CFG_ROW_BYTES:    width_reg = value[4:0];
      CFG_HEADER_BYTES: skip_reg = value[5:0];
      CFG_IMAGE_ROWS:   rows_reg = value;
      default: ;
    endcase
  endfunction

  function void take_byte(logic [7:0] value);
    int unsigned width;
    int unsigned depth;
    int unsigned g;
    pixel_beat_t beat;
    width = row_width();
    depth = image_depth();
    g = group;
    stream_bytes++;
    if (skipping) begin
      if (header_seen < skip_reg) begin
        header_seen++;
        if (header_seen >= skip_reg) skipping = 1'b0;
        return;
      end
      skipping = 1'b0;
    end
    data_bytes++;
    if (g >= RowBytesMax) g = 0;
    case (phase)
      PH_PLANE0: plane0_row[g] = value;
      PH_PLANE1: plane1_row[g] = value;
      PH_PLANE2: plane2_row[g] = value;
      PH_PLANE3: begin
        for (int i = 0; i < 8; i++) begin
          beat.color = {value[7 - i], plane2_row[g][7 - i], plane1_row[g][7 - i],
                        plane0_row[g][7 - i]};
          beat.x = 7'(g * 8 + i);
          beat.y = 8'(row);
          beat.group_end = (i == 7);
          beat.image_end = (i == 7) && (g + 1 >= width) && (row + 1 >= depth);
          pixels_due.push_back(beat);
        end
      end
    endcase
    g++;
    if (g >= width) begin
      g = 0;
      if (phase == PH_PLANE3) begin
        phase = PH_PLANE0;
        row++;
        if (row >= depth) begin
          row = 0;
          skipping = 1'b1;
          header_seen = 0;
          images++;
        end
      end else begin
        phase = plane_phase_t'(phase + 1);
      end
    end
    group = g;
  endfunction

  function void match_pixel(pixel_beat_t got);
    pixel_beat_t want;
    pixels_seen++;
    if (pixels_due.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected pixel beat: idx=%0d x=%0d y=%0d group_last=%0b image_last=%0b",
                 got.color, got.x, got.y, got.group_end, got.image_end);
      return;
    end
    want = pixels_due.pop_front();
    if (got !== want) begin
      failures++;
      if (failures <= 10)
        $display("pixel beat %0d: expected idx=%0d x=%0d y=%0d gl=%0b il=%0b,",
                 pixels_seen, want.color, want.x, want.y, want.group_end, want.image_end,
                 " got idx=%0d x=%0d y=%0d gl=%0b il=%0b",
                 got.color, got.x, got.y, got.group_end, got.image_end);
    end
  endfunction
endclass

module bitplane_row_to_chunky_decoder_unit_tb;

  localparam int unsigned SettleCycles = 40;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = CFG_ROW_BYTES;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [3:0] pixel_index;
  logic [6:0] pixel_x;
  logic [7:0] pixel_y;
  logic       group_last;
  logic       image_last;
  bit         calm = 1'b0;

  plane_merge_tracker book;

  bitplane_row_to_chunky_decoder_unit #(
    .MAX_ROW_BYTES(RowBytesMax)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_index(pixel_index),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .group_last (group_last),
    .image_last (image_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("bitplane_row_to_chunky_decoder_unit: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 15);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      book.match_pixel(pixel_beat_t'({pixel_index, pixel_x, pixel_y, group_last, image_last}));
  end

  task automatic send_byte(input logic [7:0] value);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.take_byte(value);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    book.write_reg(idx, value);
  endtask

  task automatic close_cfg();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // drain all due pixels, then let header-only work finish
  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic fill_image();
    do send_byte(8'($urandom)); while (!book.at_image_start());
  endtask

  initial begin
    logic [7:0]  opening [10] = '{8'h00, 8'hFF, 8'hF0, 8'hF0, 8'hF0, 8'hF0,
                                  8'hAA, 8'h55, 8'hCC, 8'h33};
    logic [4:0]  width_pick;
    logic [5:0]  skip_pick;
    logic [7:0]  rows_pick;
    int unsigned loop_start;
    int unsigned target;
    int unsigned image_count;

    book = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_reg(CFG_SPARE, 8'hFF);
    set_reg(CFG_ROW_BYTES, 8'h01);
    set_reg(CFG_HEADER_BYTES, 8'h02);
    set_reg(CFG_IMAGE_ROWS, 8'h02);
    close_cfg();
    foreach (opening[k]) send_byte(opening[k]);

    // cut the header short after three bytes
    settle();
    set_reg(CFG_HEADER_BYTES, 8'h06);
    set_reg(CFG_IMAGE_ROWS, 8'h01);
    close_cfg();
    repeat (3) send_byte(8'($urandom));
    settle();
    set_reg(CFG_HEADER_BYTES, 8'h02);
    close_cfg();
    fill_image();

    settle();
    set_reg(CFG_ROW_BYTES, 8'hE0);
    set_reg(CFG_HEADER_BYTES, 8'hC0);
    set_reg(CFG_IMAGE_ROWS, 8'h00);
    close_cfg();
    fill_image();

    // lower the row count mid-image
    settle();
    set_reg(CFG_IMAGE_ROWS, 8'hFF);
    set_reg(CFG_ROW_BYTES, 8'h21);
    set_reg(CFG_HEADER_BYTES, 8'h00);
    close_cfg();
    target = book.data_bytes + 24;
    while (book.data_bytes < target) send_byte(8'($urandom));
    settle();
    set_reg(CFG_IMAGE_ROWS, 8'h01);
    close_cfg();
    fill_image();

    settle();
    set_reg(CFG_ROW_BYTES, 8'h10);
    set_reg(CFG_HEADER_BYTES, 8'hFF);
    close_cfg();
    fill_image();

    loop_start = book.data_bytes;
    image_count = 0;
    while (book.data_bytes - loop_start < 300) begin
      settle();
      case ($urandom_range(0, 9))
        0:       width_pick = 5'd0;
        1:       width_pick = 5'($urandom_range(16, 31));
        default: width_pick = 5'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 7))
        0:       rows_pick = 8'd0;
        1:       rows_pick = 8'($urandom_range(5, 8));
        default: rows_pick = 8'($urandom_range(1, 3));
      endcase
      skip_pick = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(5, 63))
                                               : 6'($urandom_range(0, 4));
      set_reg(CFG_IMAGE_ROWS, rows_pick);
      set_reg(CFG_ROW_BYTES, {3'($urandom), width_pick});
      set_reg(CFG_HEADER_BYTES, {2'($urandom), skip_pick});
      close_cfg();
      calm = (image_count >= 3 && image_count < 6);
      case ($urandom_range(0, 5))
        0: begin
          if (skip_pick >= 2) begin
            repeat ($urandom_range(1, skip_pick - 1)) send_byte(8'($urandom));
            settle();
            set_reg(CFG_HEADER_BYTES, {2'($urandom), 6'($urandom_range(0, book.header_seen))});
            close_cfg();
          end
        end
        1: begin
          if (book.row_width() >= 2) begin
            target = book.data_bytes
                   + $urandom_range(1, 4 * book.row_width() * book.image_depth() - 1);
            while (book.data_bytes < target) send_byte(8'($urandom));
            settle();
            set_reg(CFG_ROW_BYTES, {3'($urandom), 5'($urandom_range(1, book.row_width() - 1))});
            close_cfg();
          end
        end
        default: ;
      endcase
      fill_image();
      image_count++;
    end
    calm = 1'b0;

    settle();
    $display("run covered %0d stream bytes, %0d of them pixel data, over %0d images",
             book.stream_bytes, book.data_bytes, book.images);
    $display("%0d pixel beats checked after %0d register writes",
             book.pixels_seen, book.reg_writes);
    if (book.failures == 0) begin
      $display("bitplane_row_to_chunky_decoder_unit: match");
    end else begin
      $display("bitplane_row_to_chunky_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule
